/* hw/rtl/sdt_pkg.sv */
// Shared constants, command codes and controller/datapath interface types.
package sdt_pkg;

    localparam int CAPACITY = 16;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDXC_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    typedef logic [KEY_W-1:0] key_t;

    // controller -> datapath
    typedef struct packed {
        logic ld_ins;      // capture key, start shift from the top entry
        logic ld_qry;      // capture key, start scan at entry 0
        logic ld_rd;       // capture index, read that entry
        logic shift_step;  // move one entry up by one position
        logic ins_place;   // write key at current position, bump count
        logic scan_step;   // advance scan by one entry
        logic res_drop;    // result: insert refused, table full
        logic res_qry;     // result: membership query
        logic res_rd;      // result: entry read
        logic res_nop;     // result: unused code
    } sdt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic i_zero;
        logic ge;          // entry under test >= key
        logic eq;          // entry under test == key
        logic scan_end;    // scan position reached count
    } sdt_stat_t;

endpackage

/* hw/rtl/sdt_ctrl.sv */
// Command sequencer for the sorted date table.
module sdt_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sdt_pkg::CMD_W-1:0] cmd,
    input  sdt_pkg::sdt_stat_t        stat,
    output sdt_pkg::sdt_cmd_t         ctl,
    output logic                      busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_RDW   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        sdt_pkg::CMD_INSERT:
                        begin
                            if (stat.full)
                            begin
                                ctl.res_drop = 1'b1;
                            end
                            else
                            begin
                                ctl.ld_ins = 1'b1;
                                state_next = ST_SHIFT;
                            end
                        end
                        sdt_pkg::CMD_QUERY:
                        begin
                            ctl.ld_qry = 1'b1;
                            state_next = ST_SCAN;
                        end
                        sdt_pkg::CMD_READ:
                        begin
                            ctl.ld_rd  = 1'b1;
                            state_next = ST_RDW;
                        end
                        sdt_pkg::CMD_NOP:
                        begin
                            ctl.res_nop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                // equal entries move up too, so the new date lands ahead of them
                if (stat.i_zero || !stat.ge)
                begin
                    ctl.ins_place = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    ctl.shift_step = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_end || stat.eq)
                begin
                    ctl.res_qry = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                end
            end
            ST_RDW:
            begin
                ctl.res_rd = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_no_start_cmd_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(ctl.ld_ins || ctl.ld_qry || ctl.ld_rd || ctl.res_drop || ctl.res_nop))
        else $error("load or immediate result issued while busy");

    a_shift_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ld_ins |=> (state_reg == ST_SHIFT))
        else $error("insert load did not enter shift");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.res_drop, ctl.res_qry, ctl.res_rd, ctl.res_nop, ctl.ins_place}))
        else $error("more than one result command in a cycle");

endmodule

/* hw/rtl/sdt_datapath.sv */
// Entry memory, count, position counter, compare and result registers.
module sdt_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sdt_pkg::sdt_cmd_t           ctl,
    output sdt_pkg::sdt_stat_t          stat,
    input  logic [sdt_pkg::DAY_W-1:0]   day,
    input  logic [sdt_pkg::MONTH_W-1:0] month,
    input  logic [sdt_pkg::YEAR_W-1:0]  year,
    input  logic [sdt_pkg::IDX_W-1:0]   read_index,
    output logic                        done,
    output logic                        found,
    output logic                        full_drop,
    output logic                        entry_valid,
    output logic [sdt_pkg::DAY_W-1:0]   out_day,
    output logic [sdt_pkg::MONTH_W-1:0] out_month,
    output logic [sdt_pkg::YEAR_W-1:0]  out_year,
    output logic [sdt_pkg::COUNT_W-1:0] count
);

    sdt_pkg::key_t mem [sdt_pkg::CAPACITY];

    sdt_pkg::key_t                    key_reg;
    sdt_pkg::key_t                    rd_data_reg;
    logic [sdt_pkg::IDX_W-1:0]        idx_reg;
    logic [sdt_pkg::CNT_W-1:0]        i_reg;
    logic [sdt_pkg::CNT_W-1:0]        i_next;
    logic [sdt_pkg::CNT_W-1:0]        count_reg;
    logic [sdt_pkg::CNT_W-1:0]        count_next;
    logic [sdt_pkg::CNT_W-1:0]        count_m1;
    logic [sdt_pkg::CNT_W-1:0]        i_m1;
    logic [sdt_pkg::CNT_W-1:0]        i_m2;
    logic [sdt_pkg::CNT_W-1:0]        i_p1;
    logic [sdt_pkg::ADDR_W-1:0]       rd_addr;
    logic                             we;
    sdt_pkg::key_t                    wdata;
    logic                             rd_ok;
    logic                             any_res;
    logic                             done_reg;
    logic                             found_reg;
    logic                             full_drop_reg;
    logic                             entry_valid_reg;
    sdt_pkg::key_t                    out_key_reg;

    assign count_m1 = count_reg - sdt_pkg::CNT_W'(1);
    assign i_m1     = i_reg - sdt_pkg::CNT_W'(1);
    assign i_m2     = i_reg - sdt_pkg::CNT_W'(2);
    assign i_p1     = i_reg + sdt_pkg::CNT_W'(1);

    always_comb
    begin
        priority if (ctl.ld_ins)
        begin
            rd_addr = count_m1[sdt_pkg::ADDR_W-1:0];
        end
        else if (ctl.ld_rd)
        begin
            rd_addr = sdt_pkg::ADDR_W'(read_index);
        end
        else if (ctl.shift_step)
        begin
            rd_addr = i_m2[sdt_pkg::ADDR_W-1:0];
        end
        else if (ctl.scan_step)
        begin
            rd_addr = i_p1[sdt_pkg::ADDR_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    assign we    = ctl.shift_step || ctl.ins_place;
    assign wdata = ctl.shift_step ? rd_data_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[i_reg[sdt_pkg::ADDR_W-1:0]] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        i_next = i_reg;
        priority if (ctl.ld_ins)
        begin
            i_next = count_reg;
        end
        else if (ctl.ld_qry)
        begin
            i_next = '0;
        end
        else if (ctl.shift_step)
        begin
            i_next = i_m1;
        end
        else if (ctl.scan_step)
        begin
            i_next = i_p1;
        end
    end

    assign count_next = ctl.ins_place ? (count_reg + sdt_pkg::CNT_W'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            i_reg     <= i_next;
            count_reg <= count_next;
            done_reg  <= any_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_ins || ctl.ld_qry)
        begin
            key_reg <= {year, month, day};
        end
        if (ctl.ld_rd)
        begin
            idx_reg <= read_index;
        end
    end

    assign stat.full     = (count_reg == sdt_pkg::CNT_W'(sdt_pkg::CAPACITY));
    assign stat.i_zero   = (i_reg == '0);
    assign stat.ge       = (rd_data_reg >= key_reg);
    assign stat.eq       = (rd_data_reg == key_reg);
    assign stat.scan_end = (i_reg >= count_reg);

    assign rd_ok   = (sdt_pkg::IDXC_W'(idx_reg) < sdt_pkg::IDXC_W'(count_reg));
    assign any_res = ctl.res_drop || ctl.res_qry || ctl.res_rd || ctl.res_nop || ctl.ins_place;

    always_ff @(posedge clk)
    begin
        if (any_res)
        begin
            found_reg       <= ctl.res_qry && stat.eq && !stat.scan_end;
            full_drop_reg   <= ctl.res_drop;
            entry_valid_reg <= ctl.res_rd && rd_ok;
            out_key_reg     <= (ctl.res_rd && rd_ok) ? rd_data_reg : '0;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign full_drop   = full_drop_reg;
    assign entry_valid = entry_valid_reg;
    assign out_day     = out_key_reg[sdt_pkg::DAY_W-1:0];
    assign out_month   = out_key_reg[sdt_pkg::DAY_W +: sdt_pkg::MONTH_W];
    assign out_year    = out_key_reg[sdt_pkg::DAY_W + sdt_pkg::MONTH_W +: sdt_pkg::YEAR_W];
    assign count       = sdt_pkg::COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sdt_pkg::CNT_W'(sdt_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_place_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins_place |=> (count_reg == $past(count_reg) + sdt_pkg::CNT_W'(1)))
        else $error("insert did not advance the count");

    a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_drop |-> stat.full)
        else $error("insert dropped with room left");

endmodule

/* hw/rtl/sorted_date_table.sv */
// Sorted date table: top level joining the command sequencer and the datapath.
//
// Keeps up to sdt_pkg::CAPACITY dates in ascending order (year, month, day) in an
// entry memory with one write port and one registered read port. A command transfer
// happens on a rising edge with start high and busy low; its one result appears on
// the result ports for exactly one cycle with done high, and the receiver cannot hold
// it off. An insert into a full table or the unused code gives its result without
// raising busy; a read waits on the registered memory read; a query compares entries
// from entry 0 until a hit or the entry count; an insert moves up each entry that is
// not below the new date, then writes it. The memory moves or compares one entry per
// cycle. busy is high from the accepting edge until the result edge, so a new command
// may be given in the cycle that shows the previous result. Entries hold no reset
// value; data from positions at or above count never reaches the result ports.
module sorted_date_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sdt_pkg::CMD_W-1:0]   cmd,
    input  logic [sdt_pkg::DAY_W-1:0]   day,
    input  logic [sdt_pkg::MONTH_W-1:0] month,
    input  logic [sdt_pkg::YEAR_W-1:0]  year,
    input  logic [sdt_pkg::IDX_W-1:0]   read_index,
    output logic                        done,
    output logic                        found,
    output logic                        full_drop,
    output logic                        entry_valid,
    output logic [sdt_pkg::DAY_W-1:0]   out_day,
    output logic [sdt_pkg::MONTH_W-1:0] out_month,
    output logic [sdt_pkg::YEAR_W-1:0]  out_year,
    output logic [sdt_pkg::COUNT_W-1:0] count
);

    sdt_pkg::sdt_cmd_t  ctl;
    sdt_pkg::sdt_stat_t stat;

    sdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    sdt_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .day         (day),
        .month       (month),
        .year        (year),
        .read_index  (read_index),
        .done        (done),
        .found       (found),
        .full_drop   (full_drop),
        .entry_valid (entry_valid),
        .out_day     (out_day),
        .out_month   (out_month),
        .out_year    (out_year),
        .count       (count)
    );

endmodule

/* tb/sv/tb_sorted_date_table.sv */
// Testbench for sorted_date_table: random and directed table commands checked against a predictor.
module tb_sorted_date_table;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        found;
        logic                        full_drop;
        logic                        entry_valid;
        logic [sdt_pkg::DAY_W-1:0]   day;
        logic [sdt_pkg::MONTH_W-1:0] month;
        logic [sdt_pkg::YEAR_W-1:0]  year;
        logic [sdt_pkg::COUNT_W-1:0] count;
    } table_result_t;

    class sorted_table_checker;
        sdt_pkg::key_t dates[sdt_pkg::CAPACITY];
        int            stored;
        table_result_t expected_results[$];
        int            errors;
        int            n_insert, n_drop, n_query, n_hit, n_read, n_valid_read, n_nop;

        function new();
            stored = 0;
            errors = 0;
            n_insert = 0; n_drop = 0; n_query = 0; n_hit = 0;
            n_read = 0; n_valid_read = 0; n_nop = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function sdt_pkg::key_t stored_key(int i);
            return dates[i];
        endfunction

        // Work out the result of one accepted command and update the table copy.
        function void note_command(logic [sdt_pkg::CMD_W-1:0] c, sdt_pkg::key_t key,
                                   logic [sdt_pkg::IDX_W-1:0] idx);
            table_result_t r;
            int            pos;
            r = '0;
            case (c)
                sdt_pkg::CMD_INSERT: begin
                    n_insert++;
                    if (stored >= sdt_pkg::CAPACITY) begin
                        r.full_drop = 1'b1;
                        n_drop++;
                    end else begin
                        pos = 0;
                        while (pos < stored && dates[pos] < key)
                            pos++;
                        for (int i = stored; i > pos; i--)
                            dates[i] = dates[i-1];
                        dates[pos] = key;
                        stored++;
                    end
                end
                sdt_pkg::CMD_QUERY: begin
                    n_query++;
                    for (int i = 0; i < stored; i++)
                        if (dates[i] == key)
                            r.found = 1'b1;
                    if (r.found)
                        n_hit++;
                end
                sdt_pkg::CMD_READ: begin
                    n_read++;
                    if (int'(idx) < stored) begin
                        r.entry_valid = 1'b1;
                        {r.year, r.month, r.day} = dates[idx];
                        n_valid_read++;
                    end
                end
                default: n_nop++;
            endcase
            r.count = sdt_pkg::COUNT_W'(stored);
            expected_results.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t exp;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing expected: %p", $realtime, got);
                return;
            end
            exp = expected_results.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch", $realtime);
                    $display("  expected found=%0b drop=%0b valid=%0b date=%0d/%0d/%0d count=%0d",
                             exp.found, exp.full_drop, exp.entry_valid,
                             exp.day, exp.month, exp.year, exp.count);
                    $display("  actual   found=%0b drop=%0b valid=%0b date=%0d/%0d/%0d count=%0d",
                             got.found, got.full_drop, got.entry_valid,
                             got.day, got.month, got.year, got.count);
                end
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [sdt_pkg::CMD_W-1:0]   cmd = '0;
    logic [sdt_pkg::DAY_W-1:0]   day = '0;
    logic [sdt_pkg::MONTH_W-1:0] month = '0;
    logic [sdt_pkg::YEAR_W-1:0]  year = '0;
    logic [sdt_pkg::IDX_W-1:0]   read_index = '0;
    logic                        busy, done, found, full_drop, entry_valid;
    logic [sdt_pkg::DAY_W-1:0]   out_day;
    logic [sdt_pkg::MONTH_W-1:0] out_month;
    logic [sdt_pkg::YEAR_W-1:0]  out_year;
    logic [sdt_pkg::COUNT_W-1:0] count;

    sorted_table_checker sb;

    sorted_date_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .day         (day),
        .month       (month),
        .year        (year),
        .read_index  (read_index),
        .done        (done),
        .found       (found),
        .full_drop   (full_drop),
        .entry_valid (entry_valid),
        .out_day     (out_day),
        .out_month   (out_month),
        .out_year    (out_year),
        .count       (count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({found, full_drop, entry_valid, out_day, out_month, out_year, count});
    end

    function automatic sdt_pkg::key_t date_of(int d, int m, int y);
        return {sdt_pkg::YEAR_W'(y), sdt_pkg::MONTH_W'(m), sdt_pkg::DAY_W'(d)};
    endfunction

    // Mostly calendar dates; now and then any bit pattern the ports allow.
    function automatic sdt_pkg::key_t random_date();
        if ($urandom_range(0, 4) == 0)
            return sdt_pkg::KEY_W'($urandom);
        return date_of($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 9999));
    endfunction

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
        cmd <= sdt_pkg::CMD_W'($urandom);
        {year, month, day} <= sdt_pkg::KEY_W'($urandom);
        read_index <= sdt_pkg::IDX_W'($urandom);
    endtask

    task automatic send(logic [sdt_pkg::CMD_W-1:0] c, sdt_pkg::key_t key,
                        logic [sdt_pkg::IDX_W-1:0] idx);
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        {year, month, day} <= key;
        read_index <= idx;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c, key, idx);
    endtask

    // Hold the sender off until every outstanding result is back.
    task automatic drain();
        idle_cycle();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic random_command(bit quiet);
        int                        r;
        sdt_pkg::key_t             key;
        logic [sdt_pkg::IDX_W-1:0] idx;
        while (!quiet && $urandom_range(0, 99) < 23)
            idle_cycle();
        r = $urandom_range(0, 99);
        key = random_date();
        idx = sdt_pkg::IDX_W'($urandom);
        if (r < 4) begin
            if (sb.stored > 0 && $urandom_range(0, 1) == 1)
                key = sb.stored_key($urandom_range(0, sb.stored - 1));
            send(sdt_pkg::CMD_INSERT, key, idx);
        end else if (r < 45) begin
            if (sb.stored > 0 && $urandom_range(0, 99) < 75) begin
                key = sb.stored_key($urandom_range(0, sb.stored - 1));
                // near miss: neighbor of a stored date
                if ($urandom_range(0, 4) == 0)
                    key = $urandom_range(0, 1) ? key + 1'b1 : key - 1'b1;
            end
            send(sdt_pkg::CMD_QUERY, key, idx);
        end else if (r < 93) begin
            if (sb.stored > 0 && $urandom_range(0, 1) == 1)
                idx = sdt_pkg::IDX_W'($urandom_range(0, sb.stored - 1));
            send(sdt_pkg::CMD_READ, key, idx);
        end else begin
            send(sdt_pkg::CMD_NOP, key, idx);
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_sorted_date_table failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // empty table, unused code
        send(sdt_pkg::CMD_READ, '0, '0);
        send(sdt_pkg::CMD_QUERY, date_of(15, 6, 2024), '1);
        send(sdt_pkg::CMD_NOP, '1, '1);
        // extremes, ties and near neighbors
        send(sdt_pkg::CMD_INSERT, date_of(15, 6, 2024), '0);
        send(sdt_pkg::CMD_INSERT, date_of(15, 6, 2024), '0);
        send(sdt_pkg::CMD_INSERT, '1, '0);
        send(sdt_pkg::CMD_INSERT, '0, '0);
        send(sdt_pkg::CMD_INSERT, date_of(1, 1, 1), '0);
        send(sdt_pkg::CMD_INSERT, date_of(31, 12, 9999), '0);
        send(sdt_pkg::CMD_INSERT, date_of(14, 6, 2024), '0);
        send(sdt_pkg::CMD_INSERT, date_of(15, 7, 2024), '0);
        send(sdt_pkg::CMD_QUERY, date_of(15, 6, 2024), '0);
        send(sdt_pkg::CMD_QUERY, '0, '0);
        send(sdt_pkg::CMD_QUERY, '1, '0);
        send(sdt_pkg::CMD_QUERY, date_of(16, 6, 2024), '0);
        send(sdt_pkg::CMD_QUERY, date_of(15, 6, 2023), '0);
        // reads around the entry count, which is now 8
        send(sdt_pkg::CMD_READ, '1, 4'd0);
        send(sdt_pkg::CMD_READ, '0, 4'd7);
        send(sdt_pkg::CMD_READ, '0, 4'd8);
        send(sdt_pkg::CMD_READ, '0, 4'd15);
        drain();

        for (int n = 0; n < 1000; n++) begin
            random_command(n >= 300 && n < 500);
            if ($urandom_range(0, 199) == 0)
                drain();
        end

        idle_cycle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3 * sdt_pkg::CAPACITY) @(posedge clk);

        $display("covered %0d inserts (%0d refused on a full table), %0d queries (%0d hits)",
                 sb.n_insert, sb.n_drop, sb.n_query, sb.n_hit);
        $display("covered %0d reads (%0d in range), %0d unused codes, final entry count %0d",
                 sb.n_read, sb.n_valid_read, sb.n_nop, sb.stored);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_sorted_date_table passed");
        else
            $display("tb_sorted_date_table failed");
        $finish;
    end
endmodule

/* sorted_date_table.f */
hw/rtl/sdt_pkg.sv
hw/rtl/sdt_ctrl.sv
hw/rtl/sdt_datapath.sv
hw/rtl/sorted_date_table.sv
tb/sv/tb_sorted_date_table.sv
